// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

   localparam int COUNT_BITS = 16;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_NULL  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] char_value;
      logic [15:0] char_count;
      logic        kept;
      logic        value_done;
   } rsp_type;

   // The reported count is limited to 16 bits whatever the counter width.
   function automatic logic [15:0] report_count(input logic [COUNT_BITS-1:0] count);
      logic [31:0] wide;
      wide = 32'(count);
      if (wide > 32'h0000_FFFF) begin
         return 16'hFFFF;
      end
      return wide[15:0];
   endfunction

endpackage

// ===== sv/jsu_parser.sv =====
module jsu_parser
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  in_byte,
   input  logic [15:0] max_length,
   output logic        res_valid,
   output rsp_type     res
);

   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_NULL = 3'd1,
      MODE_STR  = 3'd2,
      MODE_ESC  = 3'd3,
      MODE_HEX  = 3'd4
   } mode_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [1:0]             null_pos_ff, null_pos_in;
   logic [11:0]            hex_acc_ff, hex_acc_in;
   logic [1:0]             hex_seen_ff, hex_seen_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   hex_ok;
   logic [3:0]             hex_val;
   logic                   char_hit;
   logic [15:0]            char_code;
   logic                   error_hit;
   logic [15:0]            limit;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_val = 4'(in_byte - 8'h37);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_val = 4'(in_byte - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign limit = (max_length == 16'd0) ? 16'd0 : max_length - 16'd1;

   always_comb begin
      mode_in     = mode_ff;
      null_pos_in = null_pos_ff;
      hex_acc_in  = hex_acc_ff;
      hex_seen_in = hex_seen_ff;
      count_in    = count_ff;
      char_hit    = 1'b0;
      char_code   = 16'd0;
      error_hit   = 1'b0;
      res_valid   = 1'b0;
      res         = '{kind: KIND_CHAR, char_value: 16'd0, char_count: 16'd0,
                      kept: 1'b0, value_done: 1'b0};

      unique case (mode_ff)
         MODE_WAIT: begin
            if (in_byte == CH_LOW_N) begin
               mode_in     = MODE_NULL;
               null_pos_in = 2'd1;
            end else if (in_byte == CH_QUOTE) begin
               mode_in  = MODE_STR;
               count_in = '0;
            end else begin
               error_hit = 1'b1;
            end
         end
         MODE_NULL: begin
            if (in_byte != ((null_pos_ff == 2'd1) ? CH_LOW_U : CH_LOW_L)) begin
               error_hit = 1'b1;
            end else if (null_pos_ff == 2'd3) begin
               null_pos_in    = 2'd0;
               mode_in        = MODE_WAIT;
               res_valid      = 1'b1;
               res.kind       = KIND_NULL;
               res.value_done = 1'b1;
            end else begin
               null_pos_in = null_pos_ff + 2'd1;
            end
         end
         MODE_STR: begin
            if (in_byte == CH_QUOTE) begin
               mode_in        = MODE_WAIT;
               res_valid      = 1'b1;
               res.kind       = KIND_END;
               res.char_count = report_count(count_ff);
               res.value_done = 1'b1;
            end else if (in_byte == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               char_hit  = 1'b1;
               char_code = 16'(in_byte);
            end
         end
         MODE_ESC: begin
            unique case (in_byte) inside
               CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                  char_hit  = 1'b1;
                  char_code = 16'(in_byte);
               end
               CH_LOW_B: begin
                  char_hit  = 1'b1;
                  char_code = 16'h0008;
               end
               CH_LOW_F: begin
                  char_hit  = 1'b1;
                  char_code = 16'h000C;
               end
               CH_LOW_N: begin
                  char_hit  = 1'b1;
                  char_code = 16'h000A;
               end
               CH_LOW_R: begin
                  char_hit  = 1'b1;
                  char_code = 16'h000D;
               end
               CH_LOW_T: begin
                  char_hit  = 1'b1;
                  char_code = 16'h0009;
               end
               CH_LOW_U: begin
                  mode_in     = MODE_HEX;
                  hex_acc_in  = 12'd0;
                  hex_seen_in = 2'd0;
               end
               default: begin
                  error_hit = 1'b1;
               end
            endcase
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               error_hit = 1'b1;
            end else if (hex_seen_ff == 2'd3) begin
               char_hit    = 1'b1;
               char_code   = {hex_acc_ff, hex_val};
               hex_acc_in  = 12'd0;
               hex_seen_in = 2'd0;
            end else begin
               hex_acc_in  = {hex_acc_ff[7:0], hex_val};
               hex_seen_in = hex_seen_ff + 2'd1;
            end
         end
         default: begin
            mode_in = MODE_WAIT;
         end
      endcase

      if (char_hit) begin
         mode_in        = MODE_STR;
         res_valid      = 1'b1;
         res.kind       = KIND_CHAR;
         res.char_value = char_code;
         res.char_count = report_count(count_ff);
         res.kept       = (32'(count_ff) < 32'(limit));
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (error_hit) begin
         mode_in        = MODE_WAIT;
         res_valid      = 1'b1;
         res.kind       = KIND_ERROR;
         res.value_done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         null_pos_ff <= 2'd0;
         hex_acc_ff  <= 12'd0;
         hex_seen_ff <= 2'd0;
         count_ff    <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         null_pos_ff <= null_pos_in;
         hex_acc_ff  <= hex_acc_in;
         hex_seen_ff <= hex_seen_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== sv/jsu_out_reg.sv =====
module jsu_out_reg
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    take,
   output logic    out_valid,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // A new result may be loaded in the same cycle the held one is taken.
   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/json_string_unescape_decoder.sv =====
// Decodes one JSON string value (a quoted string with escapes, or the literal null) from a
// byte stream, one byte per clock when not stalled. Each accepted byte is held in an input
// register, parsed combinationally against the parser state, and any result lands in an
// output register, so a byte may be accepted every cycle when not stalled, and its result
// is offered once it moves from the input register into the output register. Throughput
// is one byte per clock when not stalled, set by the update of the parser state; a result
// that waits on rsp_ready only stalls input when the next byte also produces one.
// Decoded characters report their index and whether it is below max_length - 1; a closing
// quote reports the count, and every end, null or error result returns the parser to
// waiting for a new value. Write max_length only while the block is idle.
module json_string_unescape_decoder
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_char_value,
   output logic [15:0] rsp_char_count,
   output logic        rsp_kept,
   output logic        rsp_value_done,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [15:0] max_length_ff;
   logic        res_valid;
   rsp_type     res;
   logic        advance;
   logic        out_valid;
   rsp_type     out_data;

   assign advance     = in_valid_ff & (~res_valid | ~out_valid | rsp_ready);
   assign req_ready   = ~in_valid_ff | advance;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   jsu_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .max_length (max_length_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   jsu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & res_valid),
      .load_data (res),
      .take      (rsp_ready),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_valid      = out_valid;
   assign rsp_kind       = out_data.kind;
   assign rsp_char_value = out_data.char_value;
   assign rsp_char_count = out_data.char_count;
   assign rsp_kept       = out_data.kept;
   assign rsp_value_done = out_data.value_done;

   // A byte that cannot move on must stay put in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost or changed a stalled byte");

   // Only decoded characters carry a kept flag, and they never close the value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHAR |-> !rsp_value_done)
      else $error("character result marked as end of value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CHAR |-> rsp_value_done && !rsp_kept
         && rsp_char_value == 16'd0)
      else $error("end, null or error result has bad fields");

   // A held result is never overwritten unless it is taken in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && out_valid |-> rsp_ready)
      else $error("pending result overwritten");

endmodule
